### rtl/core/plq_pkg.sv
package plq_pkg;

  // Sizes
  localparam int CAP_DEF = 128;
  localparam int COORD_W = 16;
  localparam int COUNT_W = 8;

  // Request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_DROP   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Request as it enters the block
  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_item_t;

  // Result as it leaves the block
  typedef struct packed {
    logic                      ok;
    logic signed [COORD_W-1:0] head_x;
    logic signed [COORD_W-1:0] head_y;
    logic [COUNT_W-1:0]        count;
  } out_item_t;

  // Per-cell update control
  typedef struct packed {
    logic load_pt;
    logic shift;
  } cell_ctl_t;

endpackage

### rtl/core/plq_cell.sv
module plq_cell (
  input  logic                           clk,
  input  plq_pkg::cell_ctl_t             ctl,
  input  logic [plq_pkg::COORD_W-1:0]    pt_x,
  input  logic [plq_pkg::COORD_W-1:0]    pt_y,
  input  logic [plq_pkg::COORD_W-1:0]    nbr_x,
  input  logic [plq_pkg::COORD_W-1:0]    nbr_y,
  output logic [plq_pkg::COORD_W-1:0]    x,
  output logic [plq_pkg::COORD_W-1:0]    y,
  output logic                           match
);
  import plq_pkg::*;

  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;

  // Load the new point, or take the neighbor's point toward the head
  always_ff @(posedge clk) begin
    if (ctl.load_pt) begin
      x_r <= pt_x;
      y_r <= pt_y;
    end else if (ctl.shift) begin
      x_r <= nbr_x;
      y_r <= nbr_y;
    end
  end

  // Compare the held point against the request point
  assign match = (x_r == pt_x) && (y_r == pt_y);
  assign x     = x_r;
  assign y     = y_r;

endmodule

### rtl/core/point_list_queue.sv
// Ordered store of up to CAP (x, y) points, head at cell 0.
// Input channel: a request (append, remove matching point, drop head, clear)
// on in_req is taken at a rising edge with start high and busy low. busy is
// never raised, so one request can be issued in every cycle.
// Result channel: out_valid is high for one cycle per request, in the cycle
// after the request was taken, with out_res holding ok, the head point after
// the request (zero when empty) and the count (the count before the request
// for clear). The receiver cannot stall; every strobe is a transfer.
// Throughput is one request per cycle: the row of cells compares all held
// points in parallel, the first match is isolated with one CAP-bit
// two's-complement step, and every cell at or above it takes its upper
// neighbor's point in the same edge.
// Reset (rst_n low, synchronous) empties the store; the cell contents are
// not cleared and are never visible until written again.
module point_list_queue #(
  parameter int CAP = plq_pkg::CAP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  plq_pkg::in_item_t  in_req,
  output logic               out_valid,
  output plq_pkg::out_item_t out_res
);
  import plq_pkg::*;

  localparam int CW = $clog2(CAP + 1);

  logic [COORD_W-1:0] cell_x [CAP];
  logic [COORD_W-1:0] cell_y [CAP];
  logic [CAP-1:0]     cell_match;
  logic [CAP-1:0]     hit;
  logic [CAP-1:0]     sel;
  logic [CAP-1:0]     shift_vec;
  cell_ctl_t          ctl [CAP];

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic               out_valid_r;
  logic               ok_r;
  logic               ok_nxt;
  logic [COUNT_W-1:0] rep_r;
  logic [CW-1:0]      rep_nxt;
  logic               is_full;
  logic               is_empty;
  logic               found;
  logic               append_ok;

  // Every request completes in the cycle it is taken
  assign busy = 1'b0;

  assign is_full   = (count_r == CW'(CAP));
  assign is_empty  = (count_r == '0);
  assign append_ok = (in_req.req_type == REQ_APPEND) && !is_full;

  // Row of cells; the last cell has no upper neighbor and holds itself
  for (genvar k = 0; k < CAP; k++) begin : g_cell
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    if (k == CAP - 1) begin : g_last
      assign nx = cell_x[k];
      assign ny = cell_y[k];
    end else begin : g_mid
      assign nx = cell_x[k+1];
      assign ny = cell_y[k+1];
    end

    // Only occupied cells may match
    assign hit[k] = cell_match[k] && (CW'(k) < count_r);

    assign ctl[k].load_pt = start && append_ok && (count_r == CW'(k));
    assign ctl[k].shift   = start && shift_vec[k];

    plq_cell u_cell (
      .clk   (clk),
      .ctl   (ctl[k]),
      .pt_x  (in_req.coord_x),
      .pt_y  (in_req.coord_y),
      .nbr_x (nx),
      .nbr_y (ny),
      .x     (cell_x[k]),
      .y     (cell_y[k]),
      .match (cell_match[k])
    );
  end

  // Pick the cells that close a gap: remove uses the match row, drop the head
  always_comb begin
    sel = '0;
    case (in_req.req_type)
      REQ_REMOVE: sel = hit;
      REQ_DROP:   sel[0] = !is_empty;
      default:    sel = '0;
    endcase
  end

  // Set every bit at and above the lowest selected cell
  assign shift_vec = sel | (~sel + CAP'(1));
  assign found     = |sel;

  // Next count, success and reported count
  always_comb begin
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    rep_nxt   = count_r;
    case (in_req.req_type)
      REQ_APPEND: begin
        ok_nxt = append_ok;
        if (append_ok) count_nxt = count_r + CW'(1);
        rep_nxt = count_nxt;
      end
      REQ_REMOVE, REQ_DROP: begin
        ok_nxt = found;
        if (found) count_nxt = count_r - CW'(1);
        rep_nxt = count_nxt;
      end
      REQ_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
        rep_nxt   = count_r;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= start;
      if (start) count_r <= count_nxt;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (start) begin
      ok_r  <= ok_nxt;
      rep_r <= COUNT_W'(rep_nxt);
    end
  end

  // Head comes straight from cell 0, which already holds the new state
  assign out_valid      = out_valid_r;
  assign out_res.ok     = ok_r;
  assign out_res.head_x = is_empty ? '0 : cell_x[0];
  assign out_res.head_y = is_empty ? '0 : cell_y[0];
  assign out_res.count  = rep_r;

  // Count stays within capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("count above capacity");

  // Each transfer in yields one result in the next cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("missing result strobe");

  // Successful append grows the store by one
  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    start && (in_req.req_type == REQ_APPEND) && !is_full
    |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not grow count");

  // Clear empties the store and always reports success
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start && (in_req.req_type == REQ_CLEAR)
    |=> is_empty && out_res.ok && out_res.head_x == '0)
    else $error("clear left entries");

  // Failed request leaves the count alone
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    start && !ok_nxt |=> $stable(count_r))
    else $error("failed request changed count");

endmodule
